// File: rtl/mrug_pkg.sv
// ----------------------------------------------------------------------------
// mrug_pkg
// Shared types and constants for the mono raw to 8-bit gray unpacker.
// ----------------------------------------------------------------------------
package mrug_pkg;

    localparam int unsigned MAX_WIDTH    = 4096;
    localparam int unsigned HEIGHT_LIMIT = 4096;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned WIDTH_W  = 13;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned STRIDE_W = 14;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 14;

    // format codes
    localparam logic [MODE_W-1:0] MODE_Y10   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_Y16   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_Y10P  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_Y10BP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GRAY8 = 3'd4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FORMAT_MODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd3;

    // packed-group phases
    localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LAST = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

    typedef struct packed {
        logic             frame_end;
        logic             row_end;
        logic [PIX_W-1:0] gray_pixel;
    } t_pix;

endpackage

// File: rtl/mono_raw_unpack_to_gray8.sv
// ----------------------------------------------------------------------------
// mono_raw_unpack_to_gray8
// Unpacks a mono raw frame byte stream (Y10, Y16, Y10P, Y10BPACK, Gray8)
// into 8-bit gray pixels with row and frame end markers.
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s         in   i_s_tvalid/o_s_tready  tdata[7:0] data_byte
// m         out  o_m_tvalid/i_m_tready  tdata[7:0] gray_pixel, tlast row_end,
//                                       tuser frame_end
// cfg       in   i_cfg_valid/o_cfg_ready index[1:0], data[13:0]
//
// one byte per cycle while input ready is high; the pixel of a completing byte
// is registered in the output register, or in the skid stage on a stall
// all state but the output and skid data registers is cleared by a synchronous active-low reset, no clearing pass
// a stall on the output parks one pixel in the skid stage; input ready
// drops only while the skid stage is full
// ----------------------------------------------------------------------------
module mono_raw_unpack_to_gray8
    import mrug_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,   // [7:0] data_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [PIX_W-1:0]      o_m_tdata,   // [7:0] gray_pixel
    output logic                  o_m_tlast,
    output logic                  o_m_tuser,   // [0] frame_end
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [REG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_pix pix;
    logic emit;
    logic ready;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = ready;
    assign accept      = i_s_tvalid && ready;

    mrug_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mrug_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .o_emit   (emit),
        .o_pix    (pix)
    );

    mrug_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (emit),
        .i_pix      (pix),
        .o_ready    (ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// File: rtl/mrug_cfg.sv
// ----------------------------------------------------------------------------
// mrug_cfg
// Configuration registers and clamped width, height and stride.
// ----------------------------------------------------------------------------
module mrug_cfg
    import mrug_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [REG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    logic [MODE_W-1:0]   r_format_mode;
    logic [WIDTH_W-1:0]  r_row_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [STRIDE_W-1:0] r_row_stride;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [15:0]         packed_bits;
    logic [STRIDE_W-1:0] need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode  <= MODE_Y10;
            r_row_width    <= WIDTH_W'(640);
            r_frame_height <= HEIGHT_W'(480);
            r_row_stride   <= STRIDE_W'(1280);
        end else if (i_wr) begin
            case (i_index)
                REG_FORMAT_MODE:  r_format_mode  <= i_data[MODE_W-1:0];
                REG_ROW_WIDTH:    r_row_width    <= i_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_data[HEIGHT_W-1:0];
                REG_ROW_STRIDE:   r_row_stride   <= i_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_row_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (r_row_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_row_width;
        end

        if (r_frame_height == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (r_frame_height > HEIGHT_W'(HEIGHT_LIMIT)) begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_frame_height;
        end

        // ceil(10 * w / 8)
        packed_bits = {w_eff, 3'b000} + {2'b00, w_eff, 1'b0} + 16'd7;

        if (r_format_mode inside {MODE_Y10, MODE_Y16}) begin
            need = {w_eff, 1'b0};
        end else if (r_format_mode inside {MODE_Y10P, MODE_Y10BP}) begin
            need = {1'b0, packed_bits[15:3]};
        end else begin
            need = {1'b0, w_eff};
        end

        o_cfg.mode   = r_format_mode;
        o_cfg.width  = w_eff;
        o_cfg.height = h_eff;
        o_cfg.stride = (r_row_stride > need) ? r_row_stride : need;
    end

endmodule

// File: rtl/mrug_core.sv
// ----------------------------------------------------------------------------
// mrug_core
// Row and pixel counters, pack phase tracking and gray pixel selection.
// ----------------------------------------------------------------------------
module mrug_core
    import mrug_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_byte,
    output logic             o_emit,
    output t_pix             o_pix
);

    logic [STRIDE_W-1:0] r_byte_column, n_byte_column;
    logic [WIDTH_W-1:0]  r_pixel_column, n_pixel_column;
    logic [ROW_W-1:0]    r_row_index, n_row_index;
    logic [PIX_W-1:0]    r_held_byte;
    logic [PHASE_W-1:0]  r_pack_phase, n_pack_phase;

    logic                ph_packed;
    logic                ph_word;
    logic [PHASE_W-1:0]  ph;
    logic                emit;
    logic [PIX_W-1:0]    pix;
    logic [STRIDE_W:0]   byte_inc;
    logic [HEIGHT_W-1:0] row_inc;

    always_comb begin
        ph_word   = i_cfg.mode inside {MODE_Y10, MODE_Y16};
        ph_packed = i_cfg.mode inside {MODE_Y10P, MODE_Y10BP};
        ph = (ph_packed && (r_pack_phase > PH_LAST)) ? PH_LAST : r_pack_phase;

        emit = 1'b0;
        pix  = i_byte;
        case (i_cfg.mode)
            MODE_Y10: begin
                emit = ph[0];
                pix  = {i_byte[1:0], r_held_byte[7:2]};
            end
            MODE_Y16: begin
                emit = ph[0];
            end
            MODE_Y10P: begin
                emit = (ph != PH_LAST);
            end
            MODE_Y10BP: begin
                case (ph)
                    PH_0: emit = 1'b1;
                    PH_1: emit = 1'b0;
                    PH_2: begin
                        emit = 1'b1;
                        pix  = {r_held_byte[5:0], i_byte[7:6]};
                    end
                    PH_3: begin
                        emit = 1'b1;
                        pix  = {r_held_byte[3:0], i_byte[7:4]};
                    end
                    default: begin
                        emit = 1'b1;
                        pix  = {r_held_byte[1:0], i_byte[7:2]};
                    end
                endcase
            end
            default: emit = 1'b1;
        endcase
        emit = emit && (r_pixel_column < i_cfg.width);

        row_inc = {1'b0, r_row_index} + HEIGHT_W'(1);
        o_emit           = i_accept && emit;
        o_pix.gray_pixel = pix;
        o_pix.row_end    = ({1'b0, r_pixel_column} + 14'd1) == {1'b0, i_cfg.width};
        o_pix.frame_end  = o_pix.row_end && (row_inc == i_cfg.height);

        if (ph_word) begin
            n_pack_phase = {2'b00, ~ph[0]};
        end else if (ph_packed) begin
            n_pack_phase = (ph >= PH_LAST) ? PH_0 : ph + PHASE_W'(1);
        end else begin
            n_pack_phase = PH_0;
        end

        n_pixel_column = emit ? r_pixel_column + WIDTH_W'(1) : r_pixel_column;
        byte_inc       = {1'b0, r_byte_column} + 15'd1;
        n_byte_column  = byte_inc[STRIDE_W-1:0];
        n_row_index    = r_row_index;
        if (byte_inc >= {1'b0, i_cfg.stride}) begin
            n_byte_column  = '0;
            n_pixel_column = '0;
            n_pack_phase   = PH_0;
            n_row_index    = (row_inc >= i_cfg.height) ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_column  <= '0;
            r_pixel_column <= '0;
            r_row_index    <= '0;
            r_held_byte    <= '0;
            r_pack_phase   <= PH_0;
        end else if (i_accept) begin
            r_byte_column  <= n_byte_column;
            r_pixel_column <= n_pixel_column;
            r_row_index    <= n_row_index;
            r_held_byte    <= i_byte;
            r_pack_phase   <= n_pack_phase;
        end
    end

`ifndef SYNTH
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pack_phase <= PH_LAST)
        else $error("pack phase out of range");
`endif

endmodule

// File: rtl/mrug_skid.sv
// ----------------------------------------------------------------------------
// mrug_skid
// Output register with a skid stage so the input side never waits on
// the output ready combinationally.
// ----------------------------------------------------------------------------
module mrug_skid
    import mrug_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_pix             i_pix,
    output logic             o_ready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [PIX_W-1:0] o_m_tdata,
    output logic             o_m_tlast,
    output logic             o_m_tuser
);

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_pix r_out, n_out;
    t_pix r_skid, n_skid;
    logic pop;

    always_comb begin
        pop          = r_out_valid && i_m_tready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out       = i_pix;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_pix;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready    = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.gray_pixel;
    assign o_m_tlast  = r_out.row_end;
    assign o_m_tuser  = r_out.frame_end;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a pixel while output is empty");

    a_frame_is_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> r_out.row_end)
        else $error("frame end without row end");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && !i_m_tready) |=> r_skid_valid)
        else $error("pixel lost on stall");
`endif

endmodule
